FILE: rtl/cotw_pkg.sv
// ---------------------------------------------------------------------------
// Connection timeout wheel package
// Sizes, field widths and operation codes used by the wheel.
// ---------------------------------------------------------------------------
package cotw_pkg;

  // Wheel and table sizes.
  localparam int WHEEL_SIZE = 64;   // 2 .. 4096
  localparam int NUM_CONN   = 64;   // 1 .. 64

  // Field widths of the command and result words.
  localparam int FUNC_W    = 3;
  localparam int ID_W      = 6;
  localparam int TIMEOUT_W = 16;

  // Derived widths.
  localparam int SLOT_W  = $clog2(WHEEL_SIZE);
  localparam int CONN_AW = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_GET    = 3'd1,
    FUNC_DELETE = 3'd2,
    FUNC_UPDATE = 3'd3,
    FUNC_TICK   = 3'd4
  } func_e;

  // Result kinds.
  localparam logic KIND_GET     = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

endpackage

FILE: rtl/cotw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module cotw_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/connection_timeout_wheel.sv
// ---------------------------------------------------------------------------
// Connection timeout wheel
// Hashed timing wheel that tracks connection timeouts and reports expiries.
// ---------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. Get and delete leave busy low, so a new command may follow at once.
// Add and update go on to the write state: the accepting cycle works out the
// quotient of the timeout by the wheel size with a reciprocal multiply,
// and the write state finishes the remainder and writes the slot into the
// slot RAM. A tick scans the slot RAM one connection per cycle through its
// single read port, busy through the scan and flush. Every result word
// is shown for exactly one cycle, flagged by res_valid_o; the receiver has
// no way to hold it off, so it must take each word as it comes. A get gives
// its answer in the cycle after the command. Expired connections come out in
// ascending id order, with last_o set on the final one; a tick on an empty
// slot gives no words at all. The presence flags sit in flip-flops that
// reset clears at once, so there is no clearing pass after reset.
// ---------------------------------------------------------------------------
module connection_timeout_wheel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [cotw_pkg::FUNC_W-1:0]    func_i,
  input  logic [cotw_pkg::ID_W-1:0]      conn_id_i,
  input  logic [cotw_pkg::TIMEOUT_W-1:0] timeout_i,
  output logic                           res_valid_o,
  output logic                           kind_o,
  output logic [cotw_pkg::ID_W-1:0]      conn_id_out_o,
  output logic                           found_o,
  output logic                           last_o
);

  import cotw_pkg::*;

  // Reciprocal for an exact floor division of a timeout by the wheel size:
  // with a shift of TIMEOUT_W plus the ceiling of log2 of the divisor, the
  // rounded-up reciprocal gives the true quotient for every timeout value.
  localparam int RECIP_SH = TIMEOUT_W + SLOT_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = TIMEOUT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WHEEL_SIZE) - 64'd1) / 64'(WHEEL_SIZE));

  localparam logic [TIMEOUT_W-1:0] WHEEL_T   = TIMEOUT_W'(WHEEL_SIZE);
  localparam logic [SLOT_W:0]      WHEEL_S   = (SLOT_W + 1)'(WHEEL_SIZE);
  localparam logic [SLOT_W-1:0]    HAND_MAX  = SLOT_W'(WHEEL_SIZE - 1);
  localparam logic [CONN_AW:0]     SCAN_LAST = (CONN_AW + 1)'(NUM_CONN - 1);
  localparam logic [ID_W:0]        CONN_LIM  = (ID_W + 1)'(NUM_CONN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                state_q, state_d;
  logic [SLOT_W-1:0]     hand_q, hand_d;
  logic [NUM_CONN-1:0]   present_q, present_d;

  // Add / update pipeline.
  logic [ID_W-1:0]       id_q, id_d;
  logic [TIMEOUT_W-1:0]  tmo_q, tmo_d;
  logic [TIMEOUT_W-1:0]  quo_q, quo_d;

  // Tick scan: read issue counter, compare stage and the held-back match.
  logic [CONN_AW:0]      scan_q, scan_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [CONN_AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [CONN_AW-1:0]    pend_idx_q, pend_idx_d;

  // Result register.
  logic                  res_valid_q, res_valid_d;
  logic                  kind_q, kind_d;
  logic [ID_W-1:0]       id_out_q, id_out_d;
  logic                  found_q, found_d;
  logic                  last_q, last_d;

  // Slot RAM ports.
  logic                  ram_we;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_wdata;
  logic [SLOT_W-1:0]     ram_rdata;

  logic                  accept;
  logic [CONN_AW-1:0]    id_idx;
  logic                  id_valid;
  logic [PROD_W-1:0]     prod;
  logic [TIMEOUT_W-1:0]  quo_wheel;
  logic [TIMEOUT_W-1:0]  rem_full;
  logic [SLOT_W:0]       slot_sum;
  logic                  match;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign id_idx = conn_id_i[CONN_AW-1:0];

  // Ids at or above the table size are ignored by add, delete and update; a get reports them as not found.
  assign id_valid = ({1'b0, conn_id_i} < CONN_LIM);

  // First half of the modulo: quotient of the timeout by the wheel size.
  assign prod = PROD_W'(timeout_i) * PROD_W'(RECIP_M);

  // Second half: remainder, then hand + remainder + 1 folded once into
  // the wheel, since that sum stays below twice the wheel size.
  assign quo_wheel = quo_q * WHEEL_T;
  assign rem_full  = tmo_q - quo_wheel;
  assign slot_sum  = {1'b0, hand_q} + {1'b0, rem_full[SLOT_W-1:0]} + (SLOT_W + 1)'(1);
  assign ram_wdata = (slot_sum >= WHEEL_S) ? SLOT_W'(slot_sum - WHEEL_S)
                                           : slot_sum[SLOT_W-1:0];

  // The RAM is written only in the write state and read only during a
  // tick scan, and busy keeps the two apart, so no forwarding is needed.
  // The hand has already moved on when the scan data comes back.
  assign match = cmp_vld_q && present_q[cmp_idx_q] && (ram_rdata == hand_q);

  always_comb begin
    state_d     = state_q;
    hand_d      = hand_q;
    present_d   = present_q;
    id_d        = id_q;
    tmo_d       = tmo_q;
    quo_d       = quo_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    id_out_d    = id_out_q;
    found_d     = found_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FUNC_ADD: begin
              if (id_valid && !present_q[id_idx]) begin
                present_d[id_idx] = 1'b1;
                id_d    = conn_id_i;
                tmo_d   = timeout_i;
                quo_d   = prod[RECIP_SH +: TIMEOUT_W];
                state_d = ST_WRITE;
              end
            end
            FUNC_GET: begin
              res_valid_d = 1'b1;
              kind_d      = KIND_GET;
              id_out_d    = conn_id_i;
              found_d     = id_valid && present_q[id_idx];
              last_d      = 1'b1;
            end
            FUNC_DELETE: begin
              if (id_valid) begin
                present_d[id_idx] = 1'b0;
              end
            end
            FUNC_UPDATE: begin
              if (id_valid && present_q[id_idx]) begin
                id_d    = conn_id_i;
                tmo_d   = timeout_i;
                quo_d   = prod[RECIP_SH +: TIMEOUT_W];
                state_d = ST_WRITE;
              end
            end
            FUNC_TICK: begin
              hand_d     = (hand_q == HAND_MAX) ? '0 : hand_q + 1'b1;
              scan_d     = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        ram_re    = 1'b1;
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_q[CONN_AW-1:0];
        scan_d    = scan_q + 1'b1;
        if (scan_q == SCAN_LAST) begin
          state_d = ST_FLUSH;
        end
        // A match is held back until the next one turns up, so that the
        // final report of the tick can carry the last flag.
        if (match) begin
          present_d[cmp_idx_q] = 1'b0;
          if (pend_vld_q) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_EXPIRED;
            id_out_d    = ID_W'(pend_idx_q);
            found_d     = 1'b0;
            last_d      = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_idx_d = cmp_idx_q;
        end
      end

      ST_FLUSH: begin
        if (match) begin
          present_d[cmp_idx_q] = 1'b0;
          res_valid_d = 1'b1;
          kind_d      = KIND_EXPIRED;
          found_d     = 1'b0;
          if (pend_vld_q) begin
            // Both the held match and the final one remain: send the held
            // one now and the final one, flagged last, in the next cycle.
            id_out_d   = ID_W'(pend_idx_q);
            last_d     = 1'b0;
            pend_idx_d = cmp_idx_q;
          end else begin
            id_out_d = ID_W'(cmp_idx_q);
            last_d   = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          if (pend_vld_q) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_EXPIRED;
            id_out_d    = ID_W'(pend_idx_q);
            found_d     = 1'b0;
            last_d      = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hand_q      <= '0;
      present_q   <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      present_q   <= present_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      pend_vld_q  <= pend_vld_d;
      res_valid_q <= res_valid_d;
      id_q        <= id_d;
      tmo_q       <= tmo_d;
      quo_q       <= quo_d;
      cmp_idx_q   <= cmp_idx_d;
      pend_idx_q  <= pend_idx_d;
      kind_q      <= kind_d;
      id_out_q    <= id_out_d;
      found_q     <= found_d;
      last_q      <= last_d;
    end
  end

  cotw_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_CONN)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (id_q[CONN_AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[CONN_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o   = res_valid_q;
  assign kind_o        = kind_q;
  assign conn_id_out_o = id_out_q;
  assign found_o       = found_q;
  assign last_o        = last_q;

  // A get is answered, flagged last, in the cycle right after it is taken.
  a_get_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_GET)) |=> (res_valid_o && (kind_o == KIND_GET) && last_o))
    else $error("get command not answered in the following cycle");

  // The final expiry report of a tick leaves the wheel ready for commands.
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_EXPIRED) && last_o) |-> !busy)
    else $error("wheel still busy after the last expiry report");

  // A connection reported as expired has already been taken off the table.
  a_expired_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_EXPIRED)) |->
      (!present_q[conn_id_out_o[CONN_AW-1:0]] && !found_o))
    else $error("expired connection still marked present");

endmodule
